// ===== sv/ptt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the page table translation block: default sizes and the action codes.
// It has no dependencies. The top level imports it.
package ptt_pkg;

    // Default geometry. Each value must be a power of two.
    localparam int PTT_PAGE_WORDS      = 8;
    localparam int PTT_VIRTUAL_PAGES   = 128;
    localparam int PTT_PHYSICAL_FRAMES = 16;

    // Fixed field widths of the request and response beats.
    localparam int PTT_ACTION_W = 2;
    localparam int PTT_VADDR_W  = 10;
    localparam int PTT_WORD_W   = 32;
    localparam int PTT_IFRAME_W = 4;
    localparam int PTT_PADDR_W  = 7;
    localparam int PTT_STAMP_W  = 32;

    // Request actions. The fourth code does nothing.
    typedef enum logic [PTT_ACTION_W-1:0] {
        ACT_READ    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_INSTALL = 2'd2
    } t_action;

endpackage

// ===== sv/page_table_translate.sv =====
`timescale 1ns / 1ps
// Top level of the page table translation block.
// It depends on ptt_pkg and on ptt_ram, which holds the page table and the data words.
//
// The block takes one request beat per cycle while the output side does not stall, and
// gives one response beat for each, in order, through the stage 1 and stage 2 registers.
// The rate is set by the page table RAM. Its one read and one write port carry
// a read-modify-write per request. A write-back that lands in the same cycle as the
// next read of that page is forwarded from a bypass register. Page present marks
// reset through a row of valid bits, so no clearing pass is needed after reset.
// Data words are undefined until written. PAGE_WORDS, VIRTUAL_PAGES and
// PHYSICAL_FRAMES must be powers of two.
module page_table_translate #(
    parameter int PAGE_WORDS      = ptt_pkg::PTT_PAGE_WORDS,
    parameter int VIRTUAL_PAGES   = ptt_pkg::PTT_VIRTUAL_PAGES,
    parameter int PHYSICAL_FRAMES = ptt_pkg::PTT_PHYSICAL_FRAMES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [ptt_pkg::PTT_ACTION_W-1:0]       i_action,
    input  logic [ptt_pkg::PTT_VADDR_W-1:0]        i_vaddr,
    input  logic signed [ptt_pkg::PTT_WORD_W-1:0]  i_wdata,
    input  logic [ptt_pkg::PTT_IFRAME_W-1:0]       i_install_frame,
    input  logic                                   i_install_present,
    // Response channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [ptt_pkg::PTT_WORD_W-1:0]  o_rdata,
    output logic [ptt_pkg::PTT_PADDR_W-1:0]        o_paddr,
    output logic                                   o_fault,
    output logic [ptt_pkg::PTT_PADDR_W-1:0]        o_fault_page,
    output logic                                   o_entry_dirty,
    output logic [ptt_pkg::PTT_STAMP_W-1:0]        o_entry_stamp
);

    import ptt_pkg::*;

    localparam int OW    = $clog2(PAGE_WORDS);
    localparam int PW    = $clog2(VIRTUAL_PAGES);
    localparam int FW    = $clog2(PHYSICAL_FRAMES);
    localparam int AW    = FW + OW;
    localparam int MEM_D = PHYSICAL_FRAMES * PAGE_WORDS;
    // Table entry: present, used, dirty, frame, stamp.
    localparam int ENT_W = 3 + FW + PTT_STAMP_W;

    // Pipeline enable: everything moves when the response register can take a beat.
    logic w_en;

    // Request decode.
    logic [31:0]   w_vpage;
    logic [PW-1:0] w_pg;

    // Stage 1 registers: request held while the table read completes.
    logic                  r_s1_valid;
    t_action               r_s1_action;
    logic [PW-1:0]         r_s1_pg;
    logic [PTT_PADDR_W-1:0] r_s1_vpage;
    logic [OW-1:0]         r_s1_off;
    logic [PTT_WORD_W-1:0] r_s1_wdata;
    logic [FW-1:0]         r_s1_ifr;
    logic                  r_s1_ipr;
    logic                  r_s1_vbit;

    // Valid bits of the page table rows and the forwarding register.
    logic [VIRTUAL_PAGES-1:0] r_pg_valid;
    logic                     r_fwd_valid;
    logic [PW-1:0]            r_fwd_pg;
    logic [ENT_W-1:0]         r_fwd_entry;

    // Access counter.
    logic [PTT_STAMP_W-1:0] r_counter;
    logic [PTT_STAMP_W-1:0] n_counter;

    // Stage 2 registers: the response beat.
    logic                   r_s2_valid;
    logic                   r_s2_rd;
    logic [PTT_PADDR_W-1:0] r_s2_paddr;
    logic                   r_s2_fault;
    logic [PTT_PADDR_W-1:0] r_s2_fpage;
    logic                   r_s2_dirty;
    logic [PTT_STAMP_W-1:0] r_s2_stamp;

    // Stage 1 logic.
    logic [ENT_W-1:0]       w_tbl_q;
    logic [ENT_W-1:0]       w_entry;
    logic [ENT_W-1:0]       n_entry;
    logic                   w_old_present;
    logic                   w_old_used;
    logic                   w_old_dirty;
    logic [FW-1:0]          w_old_frame;
    logic [PTT_STAMP_W-1:0] w_old_stamp;
    logic                   w_present;
    logic                   w_used;
    logic                   w_dirty;
    logic [FW-1:0]          w_frame;
    logic [PTT_STAMP_W-1:0] w_stamp;
    logic                   w_tbl_we;
    logic                   w_data_we;
    logic                   w_rd_hit;
    logic [AW-1:0]          w_paddr;
    logic                   w_fault;
    logic [PTT_PADDR_W-1:0] w_fpage;
    logic [PTT_WORD_W-1:0]  w_data_q;

    assign w_en        = !r_s2_valid || i_out_ready;
    assign o_in_ready  = w_en;

    // Page number and table index of the incoming request.
    assign w_vpage = 32'(i_vaddr) >> OW;
    assign w_pg    = w_vpage[PW-1:0];

    // Stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_action <= t_action'(i_action);
            r_s1_pg     <= w_pg;
            r_s1_vpage  <= w_vpage[PTT_PADDR_W-1:0];
            r_s1_off    <= i_vaddr[OW-1:0];
            r_s1_wdata  <= i_wdata;
            r_s1_ifr    <= FW'(32'(i_install_frame));
            r_s1_ipr    <= i_install_present;
            r_s1_vbit   <= r_pg_valid[w_pg];
        end
    end

    // Page table memory.
    ptt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (VIRTUAL_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_en && r_s1_valid && w_tbl_we),
        .i_waddr (r_s1_pg),
        .i_wdata (n_entry),
        .i_re    (w_en),
        .i_raddr (w_pg),
        .o_rdata (w_tbl_q)
    );

    // Entry as seen by stage 1: forwarded write-back, else the RAM, else the reset value.
    always_comb begin
        if (r_fwd_valid && r_fwd_pg == r_s1_pg) begin
            w_entry = r_fwd_entry;
        end else if (r_s1_vbit) begin
            w_entry = w_tbl_q;
        end else begin
            w_entry = '0;
        end
    end

    assign {w_old_present, w_old_used, w_old_dirty, w_old_frame, w_old_stamp} = w_entry;

    // Translation and entry update.
    always_comb begin
        w_present = w_old_present;
        w_used    = w_old_used;
        w_dirty   = w_old_dirty;
        w_frame   = w_old_frame;
        w_stamp   = w_old_stamp;
        n_counter = r_counter;
        w_tbl_we  = 1'b0;
        w_data_we = 1'b0;
        w_rd_hit  = 1'b0;
        w_paddr   = '0;
        w_fault   = 1'b0;
        w_fpage   = '0;
        unique case (r_s1_action)
            ACT_READ, ACT_WRITE: begin
                if (!w_old_present) begin
                    w_fault = 1'b1;
                    w_fpage = r_s1_vpage;
                end else begin
                    w_used    = 1'b1;
                    n_counter = r_counter + 1'b1;
                    w_stamp   = n_counter;
                    w_paddr   = {w_old_frame, r_s1_off};
                    w_tbl_we  = 1'b1;
                    if (r_s1_action == ACT_WRITE) begin
                        w_dirty   = 1'b1;
                        w_data_we = 1'b1;
                    end else begin
                        w_rd_hit = 1'b1;
                    end
                end
            end
            ACT_INSTALL: begin
                w_present = r_s1_ipr;
                w_used    = 1'b0;
                w_dirty   = 1'b0;
                w_stamp   = '0;
                w_tbl_we  = 1'b1;
                if (r_s1_ipr) begin
                    w_frame = r_s1_ifr;
                    w_paddr = {r_s1_ifr, r_s1_off};
                end
            end
            default: begin
                // Unused action: nothing changes.
            end
        endcase
        n_entry = {w_present, w_used, w_dirty, w_frame, w_stamp};
    end

    // Counter, valid bits and forwarding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter   <= '0;
            r_pg_valid  <= '0;
            r_fwd_valid <= 1'b0;
        end else if (w_en) begin
            r_fwd_valid <= r_s1_valid && w_tbl_we;
            if (r_s1_valid) begin
                r_counter <= n_counter;
                if (w_tbl_we) begin
                    r_pg_valid[r_s1_pg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fwd_pg    <= r_s1_pg;
            r_fwd_entry <= n_entry;
        end
    end

    // Physical data memory.
    ptt_ram #(
        .WIDTH (PTT_WORD_W),
        .DEPTH (MEM_D)
    ) u_data (
        .i_clk   (i_clk),
        .i_we    (w_en && r_s1_valid && w_data_we),
        .i_waddr (w_paddr),
        .i_wdata (r_s1_wdata),
        .i_re    (w_en && r_s1_valid && w_rd_hit),
        .i_raddr (w_paddr),
        .o_rdata (w_data_q)
    );

    // Stage 2: response beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_rd    <= w_rd_hit;
            r_s2_paddr <= PTT_PADDR_W'(w_paddr);
            r_s2_fault <= w_fault;
            r_s2_fpage <= w_fpage;
            r_s2_dirty <= w_dirty;
            r_s2_stamp <= w_stamp;
        end
    end

    assign o_out_valid   = r_s2_valid;
    assign o_rdata       = r_s2_rd ? signed'(w_data_q) : '0;
    assign o_paddr       = r_s2_paddr;
    assign o_fault       = r_s2_fault;
    assign o_fault_page  = r_s2_fpage;
    assign o_entry_dirty = r_s2_dirty;
    assign o_entry_stamp = r_s2_stamp;

endmodule

// ===== sv/ptt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies. A read of the address being written returns the old word.
module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for page_table_translate: directed and random request beats,
// with a scoreboard that predicts each response beat and checks it field by field.
// It depends on ptt_pkg and on the page_table_translate RTL.
module tb_top;
    import ptt_pkg::*;

    localparam int PAGE_WORDS   = PTT_PAGE_WORDS;
    localparam int VPAGES       = PTT_VIRTUAL_PAGES;
    localparam int FRAMES       = PTT_PHYSICAL_FRAMES;
    localparam int MEM_WORDS    = FRAMES * PAGE_WORDS;
    localparam int RANDOM_BEATS = 1830;
    localparam int HOT_PAGES    = 10;

    // The fourth action code has no name in the package; the block ignores it.
    localparam logic [PTT_ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef struct {
        logic [PTT_ACTION_W-1:0]        action;
        logic [PTT_VADDR_W-1:0]         vaddr;
        logic signed [PTT_WORD_W-1:0]   wdata;
        logic [PTT_IFRAME_W-1:0]        iframe;
        logic                           ipresent;
    } xlate_req_t;

    typedef struct {
        logic signed [PTT_WORD_W-1:0]   rdata;
        logic [PTT_PADDR_W-1:0]         paddr;
        logic                           fault;
        logic [PTT_PADDR_W-1:0]         fault_page;
        logic                           dirty;
        logic [PTT_STAMP_W-1:0]         stamp;
    } xlate_rsp_t;

    // Shadow page table and memory, plus the queue of predicted responses.
    class xlate_scoreboard;
        bit                         present [VPAGES];
        bit                         used    [VPAGES];
        bit                         dirty   [VPAGES];
        bit [PTT_IFRAME_W-1:0]      frame   [VPAGES];
        bit [PTT_STAMP_W-1:0]       stamp   [VPAGES];
        bit [PTT_STAMP_W-1:0]       access_count;
        bit [PTT_WORD_W-1:0]        words   [MEM_WORDS];
        bit                         written [MEM_WORDS];
        xlate_rsp_t                 expected_q[$];
        int                         errors;

        function int page_of(logic [PTT_VADDR_W-1:0] vaddr);
            return (vaddr / PAGE_WORDS) % VPAGES;
        endfunction

        function int phys_of(int pg, logic [PTT_VADDR_W-1:0] vaddr);
            return ((frame[pg] % FRAMES) * PAGE_WORDS + vaddr % PAGE_WORDS) % MEM_WORDS;
        endfunction

        // Apply one accepted request to the shadow state and queue its response.
        function void note_request(xlate_req_t r);
            int         pg;
            int         pa;
            xlate_rsp_t e;
            pg = page_of(r.vaddr);
            e.rdata = '0;
            e.paddr = '0;
            e.fault = 1'b0;
            e.fault_page = '0;
            case (r.action)
                ACT_INSTALL: begin
                    present[pg] = r.ipresent;
                    if (r.ipresent) frame[pg] = r.iframe;
                    used[pg] = 1'b0;
                    dirty[pg] = 1'b0;
                    stamp[pg] = '0;
                    if (r.ipresent) e.paddr = PTT_PADDR_W'(phys_of(pg, r.vaddr));
                end
                ACT_READ, ACT_WRITE: begin
                    if (!present[pg]) begin
                        e.fault = 1'b1;
                        e.fault_page = PTT_PADDR_W'(r.vaddr / PAGE_WORDS);
                    end else begin
                        used[pg] = 1'b1;
                        if (r.action == ACT_WRITE) dirty[pg] = 1'b1;
                        access_count = access_count + 1;
                        stamp[pg] = access_count;
                        pa = phys_of(pg, r.vaddr);
                        e.paddr = PTT_PADDR_W'(pa);
                        if (r.action == ACT_WRITE) begin
                            words[pa] = r.wdata;
                            written[pa] = 1'b1;
                        end else begin
                            e.rdata = words[pa];
                        end
                    end
                end
                default: ;
            endcase
            e.dirty = dirty[pg];
            e.stamp = stamp[pg];
            expected_q.push_back(e);
        endfunction

        // Compare one accepted response with the oldest prediction.
        function void check_response(xlate_rsp_t got);
            xlate_rsp_t e;
            if (expected_q.size() == 0) begin
                $error("response beat with no request outstanding, paddr 0x%0h", got.paddr);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.rdata !== e.rdata) begin
                $error("rdata: expected %0d, got %0d", e.rdata, got.rdata);
                errors++;
            end
            if (got.paddr !== e.paddr) begin
                $error("paddr: expected 0x%0h, got 0x%0h", e.paddr, got.paddr);
                errors++;
            end
            if (got.fault !== e.fault) begin
                $error("fault: expected %0b, got %0b", e.fault, got.fault);
                errors++;
            end
            if (got.fault_page !== e.fault_page) begin
                $error("fault_page: expected %0d, got %0d", e.fault_page, got.fault_page);
                errors++;
            end
            if (got.dirty !== e.dirty) begin
                $error("entry_dirty: expected %0b, got %0b", e.dirty, got.dirty);
                errors++;
            end
            if (got.stamp !== e.stamp) begin
                $error("entry_stamp: expected %0d, got %0d", e.stamp, got.stamp);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [PTT_ACTION_W-1:0]        action;
    logic [PTT_VADDR_W-1:0]         vaddr;
    logic signed [PTT_WORD_W-1:0]   wdata;
    logic [PTT_IFRAME_W-1:0]        install_frame;
    logic                           install_present;
    logic                           out_valid;
    logic                           out_ready;
    logic signed [PTT_WORD_W-1:0]   rdata;
    logic [PTT_PADDR_W-1:0]         paddr;
    logic                           fault;
    logic [PTT_PADDR_W-1:0]         fault_page;
    logic                           entry_dirty;
    logic [PTT_STAMP_W-1:0]         entry_stamp;

    xlate_scoreboard                sb;
    int                             issued;
    bit                             send_steady;
    bit                             recv_steady;
    int                             hot_page [HOT_PAGES];

    page_table_translate u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_action          (action),
        .i_vaddr           (vaddr),
        .i_wdata           (wdata),
        .i_install_frame   (install_frame),
        .i_install_present (install_present),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_rdata           (rdata),
        .o_paddr           (paddr),
        .o_fault           (fault),
        .o_fault_page      (fault_page),
        .o_entry_dirty     (entry_dirty),
        .o_entry_stamp     (entry_stamp)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Build one request beat and drive it until accepted. A read that would touch a
    // data word never written is turned into a write, since such reads are undefined.
    task automatic issue(input logic [PTT_ACTION_W-1:0] act, input int va,
                         input logic [PTT_WORD_W-1:0] wd, input int fr, input bit pres);
        xlate_req_t r;
        int         gap;
        int         pg;
        r.action = act;
        r.vaddr = PTT_VADDR_W'(va);
        r.wdata = wd;
        r.iframe = PTT_IFRAME_W'(fr);
        r.ipresent = pres;
        pg = sb.page_of(r.vaddr);
        if (r.action == ACT_READ && sb.present[pg] && !sb.written[sb.phys_of(pg, r.vaddr)])
            r.action = ACT_WRITE;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        action <= r.action;
        vaddr <= r.vaddr;
        wdata <= r.wdata;
        install_frame <= r.iframe;
        install_present <= r.ipresent;
        do @(posedge i_clk); while (!in_ready);
        sb.note_request(r);
        issued++;
    endtask

    // Random traffic: mostly accesses to a small set of hot pages, where a fault on a
    // hot page is followed by an install and a retry, mixed with cold pages and noise.
    task automatic run_random();
        int                         roll;
        int                         pg;
        int                         va;
        bit                         hot;
        logic [PTT_ACTION_W-1:0]    act;
        logic [PTT_WORD_W-1:0]      wd;
        for (int i = 0; i < HOT_PAGES; i++) hot_page[i] = $urandom_range(0, VPAGES - 1);
        while (issued < RANDOM_BEATS + 20) begin
            roll = $urandom_range(0, 99);
            hot = $urandom_range(0, 3) != 0;
            pg = hot ? hot_page[$urandom_range(0, HOT_PAGES - 1)] : $urandom_range(0, VPAGES - 1);
            va = pg * PAGE_WORDS + $urandom_range(0, PAGE_WORDS - 1);
            wd = $urandom;
            if (roll < 8) begin
                issue(ACT_INSTALL, va, wd, $urandom_range(0, FRAMES - 1),
                      $urandom_range(0, 9) != 0);
            end else if (roll < 12) begin
                issue(ACT_NOP, va, wd, $urandom_range(0, FRAMES - 1),
                      $urandom_range(0, 1) != 0);
            end else begin
                act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
                if (hot && !sb.present[pg]) begin
                    issue(act, va, wd, 0, 1'b0);
                    issue(ACT_INSTALL, va, $urandom, $urandom_range(0, FRAMES - 1), 1'b1);
                end
                issue(act, va, wd, $urandom_range(0, FRAMES - 1), $urandom_range(0, 1) != 0);
            end
        end
    endtask

    // Response side: random stalls, then check each accepted beat.
    initial begin
        xlate_rsp_t got;
        int         gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = recv_steady ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            got.rdata = rdata;
            got.paddr = paddr;
            got.fault = fault;
            got.fault_page = fault_page;
            got.dirty = entry_dirty;
            got.stamp = entry_stamp;
            sb.check_response(got);
        end
    end

    // Main sequence: reset, directed beats, random beats, drain.
    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_READ;
        vaddr <= '0;
        wdata <= '0;
        install_frame <= '0;
        install_present <= 1'b0;
        out_ready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fault on an unmapped page, then map it and access it.
        issue(ACT_READ, 0, 0, 0, 1'b0);
        issue(ACT_INSTALL, 0, 0, 0, 1'b1);
        issue(ACT_WRITE, 0, 32'h8000_0000, 0, 1'b0);
        issue(ACT_READ, 0, 0, 0, 1'b0);
        // Highest page, highest frame, highest offset.
        issue(ACT_INSTALL, 1023, 0, 15, 1'b1);
        issue(ACT_WRITE, 1023, 32'h7FFF_FFFF, 0, 1'b0);
        issue(ACT_READ, 1023, 0, 0, 1'b0);
        issue(ACT_NOP, 1023, 32'hFFFF_FFFF, 15, 1'b1);
        issue(ACT_WRITE, 1023, 32'hFFFF_FFFF, 0, 1'b0);
        // Evict it, then fault on it with the top page number.
        issue(ACT_INSTALL, 1016, 0, 3, 1'b0);
        issue(ACT_READ, 1023, 0, 0, 1'b0);
        // Another page aliased onto the same frame sees the old data.
        issue(ACT_INSTALL, 47, 0, 15, 1'b1);
        issue(ACT_READ, 47, 0, 0, 1'b0);
        // Evicting a page that was never mapped, then a fault on it.
        issue(ACT_INSTALL, 72, 0, 10, 1'b0);
        issue(ACT_WRITE, 75, 32'h5555_5555, 0, 1'b0);
        // Zero data, the unused action on an unmapped page, a write fault.
        issue(ACT_WRITE, 1, 0, 0, 1'b0);
        issue(ACT_READ, 1, 0, 0, 1'b0);
        issue(ACT_NOP, 512, 32'hAAAA_AAAA, 0, 1'b0);
        issue(ACT_WRITE, 682, 32'hAAAA_AAAA, 0, 1'b0);
        // Remapping a used, dirty page clears its marks and stamp.
        issue(ACT_INSTALL, 0, 0, 0, 1'b1);
        issue(ACT_READ, 0, 0, 0, 1'b0);

        run_random();
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** page_table_translate: PASSED **");
        end else begin
            $display("** page_table_translate: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("** page_table_translate: FAILED **");
        $finish;
    end

endmodule
